### rtl/sksr_pkg.sv
// Package for the sorted key range search block.
// Holds field widths, request and state codes, and the binary search step.
// No dependencies.
package sksr_pkg;

   localparam int IDX_W          = 6;
   localparam int CNT_W          = 7;
   localparam int FIELD_W        = 32;
   localparam int EXT_W          = 64;
   localparam int QUEUE_DEPTH    = 2;
   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_PROBE
   } bk_state_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   idx;
      logic               wr_ok;
   } cmd_type;

   // one search lane: half-open window [lo, hx) and the last hit
   typedef struct packed {
      logic [CNT_W-1:0]   lo;
      logic [CNT_W-1:0]   hx;
      logic [CNT_W-1:0]   hit;
      logic               hit_vld;
   } lane_type;

   function automatic logic lane_active(lane_type s);
      return s.lo < s.hx;
   endfunction

   function automatic logic [CNT_W-1:0] mid_of(logic [CNT_W-1:0] lo, logic [CNT_W-1:0] hx);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hx} - {{CNT_W{1'b0}}, 1'b1};
      return sum[CNT_W:1];
   endfunction

   // right = 1 keeps searching to the right of a hit, else to the left
   function automatic lane_type lane_step(lane_type s, logic [CNT_W-1:0] mid,
                                          logic lt, logic eq, logic right);
      lane_type n;
      n = s;
      if (lane_active(s)) begin
         if (eq) begin
            n.hit     = mid;
            n.hit_vld = 1'b1;
            if (right) begin
               n.lo = mid + CNT_W'(1);
            end else begin
               n.hx = mid;
            end
         end else if (lt) begin
            n.lo = mid + CNT_W'(1);
         end else begin
            n.hx = mid;
         end
      end
      return n;
   endfunction

endpackage

### rtl/sksr_fifo.sv
// Two-entry request queue between the front and back parts.
// Depends on sksr_pkg for the queue depth.
module sksr_fifo
   import sksr_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_Q'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = CNT_Q'(count_ff + 1'b1);
         2'b01:   count_in = CNT_Q'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/sksr_front.sv
// Front part: accepts requests and classifies them for the queue.
// Depends on sksr_pkg for the command type and field widths.
module sksr_front
   import sksr_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                      start,
   input  logic                      full,
   input  logic                      req_type,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [FIELD_W-1:0] req_entry_value,
   input  logic signed [FIELD_W-1:0] req_search_key,
   output logic                      push,
   output cmd_type                   cmd,
   output logic [DATA_WIDTH-1:0]     data
);

   logic signed [EXT_W-1:0] value_ext;
   logic signed [EXT_W-1:0] key_ext;

   assign push      = start & ~full;
   assign value_ext = EXT_W'(req_entry_value);
   assign key_ext   = EXT_W'(req_search_key);

   always_comb begin
      cmd.op    = op_type'(req_type);
      cmd.idx   = req_entry_index;
      cmd.wr_ok = (32'(req_entry_index) < 32'(DEPTH));
      case (cmd.op)
         OP_QUERY: data = key_ext[DATA_WIDTH-1:0];
         default:  data = value_ext[DATA_WIDTH-1:0];
      endcase
   end

endmodule

### rtl/sksr_back.sv
// Back part: store with one write and two read ports, and the two search lanes.
// Depends on sksr_pkg for the lane step, the command type and state codes.
module sksr_back
   import sksr_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] data,
   input  logic [CNT_W-1:0]      used_count,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output logic [IDX_W-1:0]      rsp_first_index,
   output logic [IDX_W-1:0]      rsp_last_index,
   output logic [CNT_W-1:0]      rsp_match_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CMAX  = (1 << CNT_W) - 1;
   localparam int N_MAX = (DEPTH < CMAX) ? DEPTH : CMAX;

   logic signed [DATA_WIDTH-1:0] mem [DEPTH];

   bk_state_type                 state_ff, state_in;
   lane_type                     lane_l_ff, lane_l_in;
   lane_type                     lane_r_ff, lane_r_in;
   logic [CNT_W-1:0]             mid_l_ff, mid_l_in;
   logic [CNT_W-1:0]             mid_r_ff, mid_r_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic signed [DATA_WIDTH-1:0] rd_l_ff, rd_r_ff;
   logic [CNT_W-1:0]             n_used;
   logic                         mem_we;
   logic                         done;
   lane_type                     lane_init;

   logic                         rsp_valid_ff;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             first_ff, first_in;
   logic [IDX_W-1:0]             last_ff, last_in;
   logic [CNT_W-1:0]             count_ff, count_in;

   assign n_used = (used_count > CNT_W'(N_MAX)) ? CNT_W'(N_MAX) : used_count;

   always_comb begin
      lane_init = '{lo: '0, hx: n_used, hit: '0, hit_vld: 1'b0};
      state_in  = state_ff;
      lane_l_in = lane_l_ff;
      lane_r_in = lane_r_ff;
      key_in    = key_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      done      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (cmd.op == OP_QUERY) begin
                  lane_l_in = lane_init;
                  lane_r_in = lane_init;
                  key_in    = data;
                  state_in  = BK_PROBE;
               end else begin
                  mem_we = cmd.wr_ok;
               end
            end
         end
         BK_PROBE: begin
            lane_l_in = lane_step(lane_l_ff, mid_l_ff, rd_l_ff < key_ff, rd_l_ff == key_ff, 1'b0);
            lane_r_in = lane_step(lane_r_ff, mid_r_ff, rd_r_ff < key_ff, rd_r_ff == key_ff, 1'b1);
            if (!lane_active(lane_l_in) && !lane_active(lane_r_in)) begin
               done     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      mid_l_in = mid_of(lane_l_in.lo, lane_l_in.hx);
      mid_r_in = mid_of(lane_r_in.lo, lane_r_in.hx);

      found_in = lane_l_in.hit_vld & lane_r_in.hit_vld & (lane_r_in.hit >= lane_l_in.hit);
      first_in = found_in ? lane_l_in.hit[IDX_W-1:0] : '0;
      last_in  = found_in ? lane_r_in.hit[IDX_W-1:0] : '0;
      count_in = found_in ? CNT_W'(lane_r_in.hit - lane_l_in.hit + CNT_W'(1)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         lane_l_ff    <= '0;
         lane_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_l_ff    <= lane_l_in;
         lane_r_ff    <= lane_r_in;
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      mid_l_ff <= mid_l_in;
      mid_r_ff <= mid_r_in;
      key_ff   <= key_in;
      if (done) begin
         found_ff <= found_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(cmd.idx)] <= data;
      end
      rd_l_ff <= mem[AW'(mid_l_in)];
      rd_r_ff <= mem[AW'(mid_r_in)];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_first_index = first_ff;
   assign rsp_last_index  = last_ff;
   assign rsp_match_count = count_ff;

endmodule

### rtl/sorted_key_range_search_top.sv
// Top level of the sorted key range search block: front, queue, back, count register.
// Depends on sksr_pkg, sksr_front, sksr_fifo and sksr_back.
//
//   port group   direction  handshake             payload
//   req_*        in         start / busy          req_type, entry index/value, search key
//   rsp_*        out        rsp_valid strobe      found, first/last index, match count
//   csr_*        in         csr_wr_en             used_count
//
// A write request is written to the store as it is popped from the queue. A query in the
// back end first loads the key and both lanes, then probes, with one probe per cycle on each
// of the two store read ports, until neither lane is active; the result strobes the cycle
// after the last probe.
// Requests enter a two-entry queue; busy is high while it is full.
// Synchronous active-high reset clears the queue, the search control and used_count;
// the store is not cleared. Results cannot be held off.
module sorted_key_range_search_top
   import sksr_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [FIELD_W-1:0] req_entry_value,
   input  logic signed [FIELD_W-1:0] req_search_key,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [IDX_W-1:0]          rsp_first_index,
   output logic [IDX_W-1:0]          rsp_last_index,
   output logic [CNT_W-1:0]          rsp_match_count,
   input  logic                      csr_wr_en,
   input  logic [CNT_W-1:0]          csr_wr_data
);

   localparam int Q_W = $bits(cmd_type) + DATA_WIDTH;

   logic [CNT_W-1:0]      used_count_ff, used_count_in;
   logic                  push, pop, full, empty;
   cmd_type               f_cmd, b_cmd;
   logic [DATA_WIDTH-1:0] f_data, b_data;
   logic [Q_W-1:0]        q_out;

   assign used_count_in = csr_wr_en ? csr_wr_data : used_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
      end else begin
         used_count_ff <= used_count_in;
      end
   end

   assign busy = full;

   sksr_front #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .start           (start),
      .full            (full),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .push            (push),
      .cmd             (f_cmd),
      .data            (f_data)
   );

   sksr_fifo #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({f_cmd, f_data}),
      .pop   (pop),
      .rdata (q_out),
      .full  (full),
      .empty (empty)
   );

   assign b_cmd  = cmd_type'(q_out[Q_W-1:DATA_WIDTH]);
   assign b_data = q_out[DATA_WIDTH-1:0];

   sksr_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .cmd             (b_cmd),
      .data            (b_data),
      .used_count      (used_count_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index),
      .rsp_match_count (rsp_match_count)
   );

   // each query passes through the idle state before its probe state, so strobes never touch
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_first_index == '0 && rsp_last_index == '0 && rsp_match_count == '0))
      else $error("miss result not cleared");

   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_match_count == CNT_W'(CNT_W'(rsp_last_index) - CNT_W'(rsp_first_index)
                                    + CNT_W'(1))
          && rsp_last_index >= rsp_first_index))
      else $error("hit count does not match index span");

   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("queue filled without a request");

endmodule
